[rtl/hcbd_pkg.sv]
// Package for the HTTP chunked body decoder: parse state codes, status codes,
// character constants, result struct and the hex digit decoder.
// No dependencies.
`default_nettype none
package hcbd_pkg;

    localparam int SIZE_BITS = 32;
    localparam int LEN_W     = 32;
    localparam int ST_W      = 4;

    localparam logic [ST_W-1:0] ST_START    = 4'd0;
    localparam logic [ST_W-1:0] ST_SIZE     = 4'd1;
    localparam logic [ST_W-1:0] ST_EXT      = 4'd2;
    localparam logic [ST_W-1:0] ST_CR1      = 4'd3;
    localparam logic [ST_W-1:0] ST_LF1      = 4'd4;
    localparam logic [ST_W-1:0] ST_DATA     = 4'd5;
    localparam logic [ST_W-1:0] ST_CR2      = 4'd6;
    localparam logic [ST_W-1:0] ST_TRAIL    = 4'd7;
    localparam logic [ST_W-1:0] ST_TRAIL_CR = 4'd8;
    localparam logic [ST_W-1:0] ST_TRAIL_LF = 4'd9;
    localparam logic [ST_W-1:0] ST_CR3      = 4'd10;

    localparam logic [1:0] STAT_RUN  = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic [LEN_W-1:0] chunk_length;
        logic             final_chunk;
        logic [7:0]       data_byte;
        logic             data_valid;
        logic [1:0]       status;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

[rtl/hcbd_in_stage.sv]
// Input register of the chunked body decoder: holds one body byte word.
// Depends on nothing beyond the stream handshake.
`default_nettype none
module hcbd_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] in_byte
    input  wire logic       advance,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign s_tready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule
`default_nettype wire

[rtl/hcbd_fsm.sv]
// Parse state machine of the chunked body decoder: size, extension, payload
// and trailer tracking. Uses hcbd_pkg.
`default_nettype none
module hcbd_fsm (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire logic [7:0]      in_byte,
    output hcbd_pkg::result_t    res
);

    logic [hcbd_pkg::ST_W-1:0]      state_reg, state_next;
    logic [hcbd_pkg::SIZE_BITS-1:0] chunk_size_reg, chunk_size_next;
    logic [hcbd_pkg::SIZE_BITS-1:0] payload_count_reg, payload_count_next;
    logic [hcbd_pkg::LEN_W+hcbd_pkg::SIZE_BITS-1:0] len_wide;
    hcbd_pkg::hex_t hex;
    logic           take_len;

    assign hex      = hcbd_pkg::hex_decode(in_byte);
    assign len_wide = {{hcbd_pkg::LEN_W{1'b0}}, chunk_size_reg};

    always_comb begin
        state_next         = state_reg;
        chunk_size_next    = chunk_size_reg;
        payload_count_next = payload_count_reg;
        res.status         = hcbd_pkg::STAT_RUN;
        res.data_valid     = 1'b0;
        res.final_chunk    = 1'b0;
        take_len           = 1'b0;
        unique case (state_reg)
            hcbd_pkg::ST_START: begin
                payload_count_next = '0;
                if (hex.ok) begin
                    chunk_size_next = hcbd_pkg::SIZE_BITS'(hex.value);
                    state_next      = hcbd_pkg::ST_SIZE;
                end else begin
                    res.status = hcbd_pkg::STAT_BAD;
                end
            end
            hcbd_pkg::ST_SIZE: begin
                if (hex.ok) begin
                    if (chunk_size_reg[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
                        res.status = hcbd_pkg::STAT_BAD;
                    end else begin
                        chunk_size_next = {chunk_size_reg[hcbd_pkg::SIZE_BITS-5:0], hex.value};
                    end
                end else if (in_byte == hcbd_pkg::CH_CR) begin
                    state_next = hcbd_pkg::ST_CR1;
                end else begin
                    state_next = hcbd_pkg::ST_EXT;
                end
            end
            hcbd_pkg::ST_EXT: begin
                if (in_byte == hcbd_pkg::CH_CR) begin
                    state_next = hcbd_pkg::ST_CR1;
                end
            end
            hcbd_pkg::ST_CR1: begin
                if (in_byte == hcbd_pkg::CH_LF) begin
                    state_next = hcbd_pkg::ST_LF1;
                end else begin
                    res.status = hcbd_pkg::STAT_BAD;
                end
            end
            hcbd_pkg::ST_LF1: begin
                if (chunk_size_reg == '0) begin
                    state_next = (in_byte == hcbd_pkg::CH_CR) ? hcbd_pkg::ST_CR3
                                                              : hcbd_pkg::ST_TRAIL;
                end else begin
                    payload_count_next = hcbd_pkg::SIZE_BITS'(1);
                    res.data_valid     = 1'b1;
                    state_next         = hcbd_pkg::ST_DATA;
                end
            end
            hcbd_pkg::ST_DATA: begin
                if (payload_count_reg < chunk_size_reg) begin
                    payload_count_next = payload_count_reg + hcbd_pkg::SIZE_BITS'(1);
                    res.data_valid     = 1'b1;
                end else if (payload_count_reg == chunk_size_reg &&
                             in_byte == hcbd_pkg::CH_CR) begin
                    state_next = hcbd_pkg::ST_CR2;
                end else begin
                    res.status = hcbd_pkg::STAT_BAD;
                end
            end
            hcbd_pkg::ST_CR2: begin
                if (in_byte == hcbd_pkg::CH_LF) begin
                    state_next = hcbd_pkg::ST_START;
                    res.status = hcbd_pkg::STAT_DONE;
                    take_len   = 1'b1;
                end else begin
                    res.status = hcbd_pkg::STAT_BAD;
                end
            end
            hcbd_pkg::ST_TRAIL: begin
                if (in_byte == hcbd_pkg::CH_CR) begin
                    state_next = hcbd_pkg::ST_TRAIL_CR;
                end
            end
            hcbd_pkg::ST_TRAIL_CR: begin
                if (in_byte == hcbd_pkg::CH_LF) begin
                    state_next = hcbd_pkg::ST_TRAIL_LF;
                end else begin
                    res.status = hcbd_pkg::STAT_BAD;
                end
            end
            hcbd_pkg::ST_TRAIL_LF: begin
                state_next = (in_byte == hcbd_pkg::CH_CR) ? hcbd_pkg::ST_CR3
                                                          : hcbd_pkg::ST_TRAIL;
            end
            hcbd_pkg::ST_CR3: begin
                if (in_byte == hcbd_pkg::CH_LF) begin
                    res.status      = hcbd_pkg::STAT_DONE;
                    res.final_chunk = 1'b1;
                    take_len        = 1'b1;
                end else begin
                    res.status = hcbd_pkg::STAT_BAD;
                end
            end
            default: begin
                res.status = hcbd_pkg::STAT_BAD;
            end
        endcase
        res.data_byte    = res.data_valid ? in_byte : 8'd0;
        res.chunk_length = take_len ? len_wide[hcbd_pkg::LEN_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= hcbd_pkg::ST_START;
            chunk_size_reg    <= '0;
            payload_count_reg <= '0;
        end else if (step) begin
            state_reg         <= state_next;
            chunk_size_reg    <= chunk_size_next;
            payload_count_reg <= payload_count_next;
        end
    end

    a_data_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == hcbd_pkg::ST_DATA |-> payload_count_reg <= chunk_size_reg)
        else $error("payload count ran past chunk size");

    a_bad_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.status == hcbd_pkg::STAT_BAD
        |=> $stable(state_reg) && $stable(chunk_size_reg))
        else $error("malformed byte changed parse state");

    a_payload_running: assert property (@(posedge aclk) disable iff (!aresetn)
        res.data_valid |-> res.status == hcbd_pkg::STAT_RUN &&
                           (state_reg == hcbd_pkg::ST_LF1 || state_reg == hcbd_pkg::ST_DATA))
        else $error("payload byte outside payload states");

endmodule
`default_nettype wire

[rtl/hcbd_out_stage.sv]
// Result register of the chunked body decoder: holds one result word for
// the master side. Uses hcbd_pkg.
`default_nettype none
module hcbd_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              res_valid,
    input  hcbd_pkg::result_t      res,
    output logic                   advance,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,   // [7:0] data_byte, [39:8] chunk_length
    output logic [2:0]             m_tuser,   // [1:0] status, [2] data_valid
    output logic                   m_tlast    // final_chunk
);

    logic              valid_reg;
    hcbd_pkg::result_t res_reg;

    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.chunk_length, res_reg.data_byte};
    assign m_tuser  = {res_reg.data_valid, res_reg.status};
    assign m_tlast  = res_reg.final_chunk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire

[rtl/http_chunked_body_decoder_unit.sv]
// HTTP/1.1 chunked body decoder, one body byte word in and one result word out.
// A result word shows on m_ at the edge its byte leaves the input register.
// Throughput: one word per cycle while m_tready does not hold the result register.
// Reset: synchronous active-low aresetn empties both registers and returns the
// parser to waiting for the first size digit; no clearing pass.
`default_nettype none
module http_chunked_body_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] data_byte, [39:8] chunk_length
    output logic [2:0]       m_tuser,   // [1:0] status, [2] data_valid
    output logic             m_tlast    // final_chunk
);

    logic              advance;
    logic              byte_valid;
    logic [7:0]        byte_data;
    hcbd_pkg::result_t res;

    hcbd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    hcbd_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (byte_valid && advance),
        .in_byte (byte_data),
        .res     (res)
    );

    hcbd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (byte_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire
